// ----- rtl/core/hist_pkg.sv -----
// Shared types and constants for the byte value histogram.
// No dependencies; imported by every module of the block.
package hist_pkg;

    localparam int NUM_BINS    = 256;
    localparam int COUNT_WIDTH = 24;
    localparam int IDX_W       = $clog2(NUM_BINS);
    localparam int OUT_W       = 24;
    localparam int ACTION_W    = 2;
    localparam int SAMPLE_W    = 8;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_READ,
        OP_READ_ZERO,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_cmd;

endpackage

// ----- rtl/core/hist_front.sv -----
// Front end: accepts items and classifies them into back-end commands.
// Depends on hist_pkg.
module hist_front
    import hist_pkg::*;
(
    input  logic                i_start,
    input  logic                i_full,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [SAMPLE_W-1:0] i_sample_or_bin,
    output logic                o_push,
    output t_cmd                o_cmd
);

    logic w_in_range;
    logic w_keep;

    assign w_in_range = (32'(i_sample_or_bin) < 32'(NUM_BINS));

    always_comb begin
        w_keep    = 1'b0;
        o_cmd.op  = OP_ADD;
        o_cmd.idx = IDX_W'(i_sample_or_bin);
        unique case (i_action)
            ACT_ADD: begin
                w_keep   = w_in_range;
                o_cmd.op = OP_ADD;
            end
            ACT_READ: begin
                w_keep   = 1'b1;
                o_cmd.op = w_in_range ? OP_READ : OP_READ_ZERO;
            end
            ACT_CLEAR: begin
                w_keep   = 1'b1;
                o_cmd.op = OP_CLEAR;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    // drop items that change nothing and return nothing
    assign o_push = i_start && !i_full && w_keep;

endmodule

// ----- rtl/core/hist_fifo.sv -----
// Short command queue between front and back end.
// Depends on hist_pkg; the head is taken whenever the queue is not empty.
module hist_fifo
    import hist_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_vld,
    output t_cmd o_cmd
);

    t_cmd                  r_data [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_pop;

    assign o_full = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_vld  = (r_count != '0);
    assign w_pop  = o_vld;
    assign o_cmd  = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/core/hist_back.sv -----
// Back end: bin memory with read-modify-write pipeline and forwarding.
// Depends on hist_pkg.
module hist_back
    import hist_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  t_cmd             i_cmd,
    output logic             o_valid,
    output logic [OUT_W-1:0] o_bin_count
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]    r_bin_vld;

    logic                   r_s1_vld;
    t_cmd                   r_s1_cmd;
    logic [COUNT_WIDTH-1:0] r_rdata;

    logic                   r_fwd_vld;
    logic [IDX_W-1:0]       r_fwd_idx;
    logic [COUNT_WIDTH-1:0] r_fwd_data;

    logic [COUNT_WIDTH-1:0] w_cur;
    logic [COUNT_WIDTH-1:0] w_new;
    logic                   w_wr_en;
    logic                   w_clr;
    logic                   w_rd;

    // current count: last write wins over the stale read, cleared bins read zero
    always_comb begin
        if (r_fwd_vld && (r_fwd_idx == r_s1_cmd.idx)) begin
            w_cur = r_fwd_data;
        end else if (r_bin_vld[r_s1_cmd.idx]) begin
            w_cur = r_rdata;
        end else begin
            w_cur = '0;
        end
    end

    assign w_new   = (w_cur == COUNT_MAX) ? w_cur : w_cur + 1'b1;
    assign w_wr_en = r_s1_vld && (r_s1_cmd.op == OP_ADD);
    assign w_clr   = r_s1_vld && (r_s1_cmd.op == OP_CLEAR);
    assign w_rd    = r_s1_vld && ((r_s1_cmd.op == OP_READ) || (r_s1_cmd.op == OP_READ_ZERO));

    // memory read and write
    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_rdata <= r_mem[i_cmd.idx];
        end
        if (w_wr_en) begin
            r_mem[r_s1_cmd.idx] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_bin_vld <= '0;
            r_fwd_vld <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            o_valid  <= w_rd;
            if (w_clr) begin
                r_bin_vld <= '0;
                r_fwd_vld <= 1'b0;
            end else if (w_wr_en) begin
                r_bin_vld[r_s1_cmd.idx] <= 1'b1;
                r_fwd_vld               <= 1'b1;
            end else begin
                r_fwd_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_s1_cmd <= i_cmd;
        end
        if (w_wr_en) begin
            r_fwd_idx  <= r_s1_cmd.idx;
            r_fwd_data <= w_new;
        end
        if (w_rd) begin
            o_bin_count <= (r_s1_cmd.op == OP_READ) ? OUT_W'(w_cur) : '0;
        end
    end

endmodule

// ----- rtl/core/byte_value_histogram_top.sv -----
// Top level of the 256-bin byte value histogram.
// Depends on hist_pkg, hist_front, hist_fifo and hist_back.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------------
//  input   | i_action, i_sample_or_bin               | transfer when start && !busy
//  result  | o_bin_count                             | o_valid strobe, one cycle
//
// Cycles: one item per clock sustained while busy is low; the back end retires
// one command per cycle through its bin memory (one read port, one write
// port), forwarding the previous write so that adds to the same bin can follow
// each other directly. A read result passes through the command queue and the
// back end's stage register before it is registered onto o_valid.
// Reset: synchronous, active low; the per-bin valid flags clear at once, so
// there is no clearing sweep. A clear item resets all the same flags together.
// Stalls: busy rises only when the command queue is full; the result side
// cannot stall and is never held.
module byte_value_histogram_top
    import hist_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [SAMPLE_W-1:0] i_sample_or_bin,
    output logic                o_valid,
    output logic [OUT_W-1:0]    o_bin_count
);

    logic w_push;
    t_cmd w_front_cmd;
    logic w_full;
    logic w_q_vld;
    t_cmd w_q_cmd;

    assign busy = w_full;

    // classify: drop unused codes and out-of-range adds
    hist_front u_front (
        .i_start         (start),
        .i_full          (w_full),
        .i_action        (i_action),
        .i_sample_or_bin (i_sample_or_bin),
        .o_push          (w_push),
        .o_cmd           (w_front_cmd)
    );

    // decouple accept from execution
    hist_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .o_vld   (w_q_vld),
        .o_cmd   (w_q_cmd)
    );

    // execute against the bin memory
    hist_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (w_q_vld),
        .i_cmd       (w_q_cmd),
        .o_valid     (o_valid),
        .o_bin_count (o_bin_count)
    );

endmodule
